>>> hw/rtl/windowed_pid_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed PID controller
// Checks sampled on aclk; the first form is masked while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PID_CONTROLLER_TOP_DEFINES_SVH
`define WINDOWED_PID_CONTROLLER_TOP_DEFINES_SVH

// property checked outside reset
`define WPID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property that must also hold across reset
`define WPID_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hw/rtl/wpid_pkg.sv
// ----------------------------------------------------------------------------
// wpid_pkg
// Shared constants, register codes and types of the windowed PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package wpid_pkg;

    localparam int RING_DEPTH     = 16;
    localparam int HALF_DEPTH     = RING_DEPTH / 2;
    // window means are arithmetic shifts, so HALF_DEPTH is a power of two
    localparam int HALF_SHIFT     = $clog2(HALF_DEPTH);
    localparam int GAIN_FRAC_BITS = 8;

    localparam int DATA_W = 16;
    localparam int ERR_W  = DATA_W + 1;
    localparam int P_W    = 17;
    localparam int D_W    = 18;
    localparam int SUM_W  = ERR_W + $clog2(RING_DEPTH);
    localparam int PROD_P_W = DATA_W + P_W;
    localparam int PROD_I_W = DATA_W + DATA_W;
    localparam int PROD_D_W = DATA_W + D_W;
    localparam int ACC_W    = PROD_D_W + 2;

    localparam logic signed [SUM_W:0] D_SAT_HI = (SUM_W + 1)'((2 ** (D_W - 1)) - 1);
    localparam logic signed [SUM_W:0] D_SAT_LO = (SUM_W + 1)'(-(2 ** (D_W - 1)));

    // result packing, lowest bit first
    localparam int OUT_BITS   = DATA_W + P_W + DATA_W + D_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT   = 3'd0,
        CFG_GAIN_P     = 3'd1,
        CFG_GAIN_I     = 3'd2,
        CFG_GAIN_D     = 3'd3,
        CFG_LIMIT_HIGH = 3'd4,
        CFG_LIMIT_LOW  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] recent;
        logic signed [SUM_W-1:0] older;
    } wpid_sums_t;

endpackage

`default_nettype wire

>>> hw/rtl/wpid_cell.sv
// ----------------------------------------------------------------------------
// wpid_cell
// One slot of the error delay line; takes its neighbour's error on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module wpid_cell (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   shift_en,
    input  wire logic signed [wpid_pkg::ERR_W-1:0]      d_in,
    output logic signed [wpid_pkg::ERR_W-1:0]           q_out
);

    logic signed [wpid_pkg::ERR_W-1:0] err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= '0;
        end else if (shift_en) begin
            err_reg <= d_in;
        end
    end

    assign q_out = err_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wpid_window.sv
// ----------------------------------------------------------------------------
// wpid_window
// Chain of error cells with the running sums of the newer and older halves.
// ----------------------------------------------------------------------------
`default_nettype none

module wpid_window (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   shift_en,
    input  wire logic signed [wpid_pkg::ERR_W-1:0]      err,
    output wpid_pkg::wpid_sums_t                        sums
);

    localparam int SW = wpid_pkg::SUM_W;
    localparam int EW = wpid_pkg::ERR_W;

    // tap[k] holds the error from k+1 transactions back
    logic signed [EW-1:0] tap [wpid_pkg::RING_DEPTH];
    logic signed [EW-1:0] moving;
    logic signed [EW-1:0] leaving;
    logic signed [SW-1:0] recent_reg, recent_next;
    logic signed [SW-1:0] older_reg, older_next;

    genvar k;
    generate
        for (k = 0; k < wpid_pkg::RING_DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                wpid_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .d_in     (err),
                    .q_out    (tap[k])
                );
            end else begin : g_body
                wpid_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .d_in     (tap[k-1]),
                    .q_out    (tap[k])
                );
            end
        end
    endgenerate

    assign moving  = tap[wpid_pkg::HALF_DEPTH-1];
    assign leaving = tap[wpid_pkg::RING_DEPTH-1];

    always_comb begin
        recent_next = recent_reg + {{(SW-EW){err[EW-1]}}, err}
                                 - {{(SW-EW){moving[EW-1]}}, moving};
        older_next  = older_reg + {{(SW-EW){moving[EW-1]}}, moving}
                                - {{(SW-EW){leaving[EW-1]}}, leaving};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            older_reg  <= '0;
        end else if (shift_en) begin
            recent_reg <= recent_next;
            older_reg  <= older_next;
        end
    end

    assign sums.recent = recent_reg;
    assign sums.older  = older_reg;

endmodule

`default_nettype wire

>>> hw/rtl/windowed_pid_controller_top.sv
// Pipeline: an accepted sample passes five register stages in order (window sums,
// terms/integral, products, sum, clamp) before its result shows on m_tvalid.
// Throughput: one sample per cycle; each stage holds one transaction and stages
// drain independently, so only a full pipeline stalls s_tready.
// Reset (aresetn low, synchronous): error line, window sums, integral and the
// pipeline valid flags are cleared at once and the registers return to their defaults.
// ----------------------------------------------------------------------------
// windowed_pid_controller_top
// Windowed PID controller with clamped integral and clamped output (Q8.8 gains).
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_pid_controller_top (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    // sample stream
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    input  wire logic [wpid_pkg::DATA_W-1:0]                s_tdata,  // process_value
    // result stream
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    // drive_value[15:0], p_term[32:16], i_term[48:33], d_term[66:49], zero pad
    output logic [wpid_pkg::M_TDATA_W-1:0]                  m_tdata,
    // register writes
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [wpid_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  wire logic [wpid_pkg::DATA_W-1:0]                cfg_data
);

    localparam int DW = wpid_pkg::DATA_W;
    localparam int EW = wpid_pkg::ERR_W;
    localparam int SW = wpid_pkg::SUM_W;
    localparam int PW = wpid_pkg::P_W;
    localparam int QW = wpid_pkg::D_W;
    localparam int AW = wpid_pkg::ACC_W;

    // ---------------- configuration ----------------
    logic signed [DW-1:0] setpoint_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DW-1:0] limit_high_reg, limit_low_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg   <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_high_reg <= 16'sh7FFF;
            limit_low_reg  <= 16'sh8000;
        end else if (cfg_valid && cfg_ready) begin
            case (wpid_pkg::cfg_reg_t'(cfg_index))
                wpid_pkg::CFG_SETPOINT:   setpoint_reg   <= cfg_data;
                wpid_pkg::CFG_GAIN_P:     gain_p_reg     <= cfg_data;
                wpid_pkg::CFG_GAIN_I:     gain_i_reg     <= cfg_data;
                wpid_pkg::CFG_GAIN_D:     gain_d_reg     <= cfg_data;
                wpid_pkg::CFG_LIMIT_HIGH: limit_high_reg <= cfg_data;
                wpid_pkg::CFG_LIMIT_LOW:  limit_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage flow control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic free1, free2, free3, free4, free5;
    logic accept;

    assign free5    = !s5_valid_reg || m_tready;
    assign free4    = !s4_valid_reg || free5;
    assign free3    = !s3_valid_reg || free4;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;
    assign s_tready = free1;
    assign accept   = s_tvalid && free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (free1) s1_valid_reg <= s_tvalid;
            if (free2) s2_valid_reg <= s1_valid_reg;
            if (free3) s3_valid_reg <= s2_valid_reg;
            if (free4) s4_valid_reg <= s3_valid_reg;
            if (free5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- stage 1: error line and window sums ----------------
    logic signed [EW-1:0]  err;
    wpid_pkg::wpid_sums_t  sums;

    assign err = {s_tdata[DW-1], s_tdata} - {setpoint_reg[DW-1], setpoint_reg};

    wpid_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept),
        .err      (err),
        .sums     (sums)
    );

    // ---------------- stage 2: terms and integral ----------------
    logic signed [SW-1:0]  recent_mean, older_mean;
    logic signed [PW-1:0]  p_next;
    logic signed [SW:0]    d_full;
    logic signed [QW-1:0]  d_next;
    logic signed [DW+1:0]  i_sum;
    logic signed [DW-1:0]  integral_next;
    logic signed [PW-1:0]  p2_reg;
    logic signed [QW-1:0]  d2_reg;
    logic signed [DW-1:0]  integral_reg;

    always_comb begin
        recent_mean = sums.recent >>> wpid_pkg::HALF_SHIFT;
        older_mean  = sums.older >>> wpid_pkg::HALF_SHIFT;
        p_next      = recent_mean[PW-1:0];
        d_full      = {{(SW+1-PW){p_next[PW-1]}}, p_next} - {older_mean[SW-1], older_mean};
        if (d_full > wpid_pkg::D_SAT_HI) begin
            d_next = wpid_pkg::D_SAT_HI[QW-1:0];
        end else if (d_full < wpid_pkg::D_SAT_LO) begin
            d_next = wpid_pkg::D_SAT_LO[QW-1:0];
        end else begin
            d_next = d_full[QW-1:0];
        end
        // anti-windup: upper limit is tested first
        i_sum = {{2{integral_reg[DW-1]}}, integral_reg} + {p_next[PW-1], p_next};
        if (i_sum > $signed({{2{limit_high_reg[DW-1]}}, limit_high_reg})) begin
            integral_next = limit_high_reg;
        end else if (i_sum < $signed({{2{limit_low_reg[DW-1]}}, limit_low_reg})) begin
            integral_next = limit_low_reg;
        end else begin
            integral_next = i_sum[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
        end else if (free2 && s1_valid_reg) begin
            integral_reg <= integral_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (free2 && s1_valid_reg) begin
            p2_reg <= p_next;
            d2_reg <= d_next;
        end
    end

    // ---------------- stage 3: gain products ----------------
    logic signed [wpid_pkg::PROD_P_W-1:0] prod_p_reg;
    logic signed [wpid_pkg::PROD_I_W-1:0] prod_i_reg;
    logic signed [wpid_pkg::PROD_D_W-1:0] prod_d_reg;
    logic signed [PW-1:0] p3_reg;
    logic signed [DW-1:0] i3_reg;
    logic signed [QW-1:0] d3_reg;

    always_ff @(posedge aclk) begin
        if (free3 && s2_valid_reg) begin
            prod_p_reg <= gain_p_reg * p2_reg;
            prod_i_reg <= gain_i_reg * integral_reg;
            prod_d_reg <= gain_d_reg * d2_reg;
            p3_reg     <= p2_reg;
            i3_reg     <= integral_reg;
            d3_reg     <= d2_reg;
        end
    end

    // ---------------- stage 4: weighted sum ----------------
    logic signed [AW-1:0] acc_next, acc4_reg;
    logic signed [PW-1:0] p4_reg;
    logic signed [DW-1:0] i4_reg;
    logic signed [QW-1:0] d4_reg;

    assign acc_next = {{(AW-wpid_pkg::PROD_P_W){prod_p_reg[wpid_pkg::PROD_P_W-1]}}, prod_p_reg}
                    + {{(AW-wpid_pkg::PROD_I_W){prod_i_reg[wpid_pkg::PROD_I_W-1]}}, prod_i_reg}
                    + {{(AW-wpid_pkg::PROD_D_W){prod_d_reg[wpid_pkg::PROD_D_W-1]}}, prod_d_reg};

    always_ff @(posedge aclk) begin
        if (free4 && s3_valid_reg) begin
            acc4_reg <= acc_next;
            p4_reg   <= p3_reg;
            i4_reg   <= i3_reg;
            d4_reg   <= d3_reg;
        end
    end

    // ---------------- stage 5: scale, clamp, output register ----------------
    logic signed [AW-1:0] scaled;
    logic signed [DW-1:0] drive_next, drive_reg;
    logic signed [PW-1:0] p5_reg;
    logic signed [DW-1:0] i5_reg;
    logic signed [QW-1:0] d5_reg;

    always_comb begin
        scaled = acc4_reg >>> wpid_pkg::GAIN_FRAC_BITS;
        if (scaled > $signed({{(AW-DW){limit_high_reg[DW-1]}}, limit_high_reg})) begin
            drive_next = limit_high_reg;
        end else if (scaled < $signed({{(AW-DW){limit_low_reg[DW-1]}}, limit_low_reg})) begin
            drive_next = limit_low_reg;
        end else begin
            drive_next = scaled[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (free5 && s4_valid_reg) begin
            drive_reg <= drive_next;
            p5_reg    <= p4_reg;
            i5_reg    <= i4_reg;
            d5_reg    <= d4_reg;
        end
    end

    assign m_tvalid = s5_valid_reg;
    assign m_tdata  = {{(wpid_pkg::M_TDATA_W - wpid_pkg::OUT_BITS){1'b0}},
                       d5_reg, i5_reg, p5_reg, drive_reg};

endmodule

`default_nettype wire

>>> hw/rtl/wpid_checker.sv
// ----------------------------------------------------------------------------
// wpid_checker
// Port-level checks on the windowed PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_pid_controller_top_defines.svh"

module wpid_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [wpid_pkg::M_TDATA_W-1:0]      m_tdata,
    input wire logic                                cfg_ready
);

    // pipeline is empty straight after reset
    `WPID_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // an empty output stage always frees the input side
    `WPID_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with output empty")

    `WPID_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[wpid_pkg::M_TDATA_W-1:wpid_pkg::OUT_BITS] == '0),
        "tdata padding not zero")

    `WPID_ASSERT(a_cfg_ready, cfg_ready, "register port not ready")

    // stalled transaction is held
    `WPID_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "stalled result changed")

endmodule

bind windowed_pid_controller_top wpid_checker u_wpid_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
